FILE: sv/clid_pkg.sv
// Package for the circular list insert/delete unit.
// Holds request/response words, opcodes, status codes and the
// controller/datapath command and status types. No dependencies.
package clid_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 5;

  // Request opcodes; the two remaining codes are ignored
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_OUT_W-1:0]    count;
  } rsp_t;

  // Kind of work a request turns into once it is checked
  typedef enum logic [2:0] {
    K_NONE,       // rejected or unused opcode: report only
    K_INS_EMPTY,  // insert into an empty list
    K_INS_END,    // insert at front or back of a non-empty list
    K_INS_MID,    // insert after the element at position-1
    K_DEL_ONLY,   // delete the single element
    K_DEL_HEAD,   // delete the head of a longer list
    K_DEL_MID     // delete a later element
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_VICTIM,
    S_LINK_NEW,
    S_LINK_PREV,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic fetch;
    logic victim;
    logic link_new;
    logic link_prev;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_t dec_kind;
    kind_t kind;
    logic  walk_done;
  } sts_t;

endpackage

FILE: sv/clid_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the element and link stores. No dependencies.
module clid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and hold read data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/clid_ctrl.sv
// Controller state machine for the circular list unit.
// Depends on clid_pkg; drives commands into clid_dp.
module clid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  clid_pkg::sts_t sts,
  output clid_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import clid_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the walk, the reads and the link updates per request kind
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (sts.dec_kind)
            K_INS_EMPTY: state_next = S_LINK_NEW;
            K_DEL_ONLY:  state_next = S_FETCH;
            K_INS_END, K_INS_MID, K_DEL_HEAD, K_DEL_MID: state_next = S_WALK;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = (sts.kind == K_INS_END) ? S_LINK_NEW : S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (sts.kind)
          K_INS_MID: state_next = S_LINK_NEW;
          K_DEL_MID: state_next = S_VICTIM;
          default:   state_next = S_FINISH;
        endcase
      end
      S_VICTIM:    state_next = S_FINISH;
      S_LINK_NEW:  state_next = (sts.kind == K_INS_EMPTY) ? S_FINISH : S_LINK_PREV;
      S_LINK_PREV: state_next = S_FINISH;
      S_FINISH:    state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Decode state into datapath commands and handshake outputs
  always_comb begin
    cmd.load      = (state == S_IDLE) && start;
    cmd.walk      = (state == S_WALK);
    cmd.fetch     = (state == S_FETCH);
    cmd.victim    = (state == S_VICTIM);
    cmd.link_new  = (state == S_LINK_NEW);
    cmd.link_prev = (state == S_LINK_PREV);
    cmd.finish    = (state == S_FINISH);
    busy          = (state != S_IDLE);
    done          = (state == S_DONE);
  end

endmodule

FILE: sv/clid_dp.sv
// Datapath for the circular list unit: request check, list registers,
// free map, link walker and the element and link stores.
// Depends on clid_pkg and clid_ram; commanded by clid_ctrl.
module clid_dp #(
  parameter int CAPACITY = clid_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  clid_pkg::cmd_t cmd,
  input  clid_pkg::req_t req,
  output clid_pkg::sts_t sts,
  output clid_pkg::rsp_t rsp
);
  import clid_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  req_t              req_q;
  kind_t             kind;
  logic [IDX_W-1:0]  cur;
  logic              pend;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [CAPACITY-1:0] free_map;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  vic;
  logic [STAT_W-1:0] status_q;
  logic [VAL_W-1:0]  removed_q;

  logic [CMP_W-1:0]  n_w, pos_w, dec_k;
  kind_t             dec_kind;
  logic [STAT_W-1:0] dec_status;
  logic [IDX_W-1:0]  free_slot;
  logic [IDX_W-1:0]  eff;
  logic              walk_done;
  logic              is_del;

  logic              link_we, link_re;
  logic [IDX_W-1:0]  link_waddr, link_wdata, link_raddr, link_rdata;
  logic              elem_re;
  logic [IDX_W-1:0]  elem_raddr;
  logic [VAL_W-1:0]  elem_rdata;

  assign n_w   = CMP_W'(count);
  assign pos_w = CMP_W'(req.position);

  // Check the request against the current count
  always_comb begin
    dec_kind   = K_NONE;
    dec_status = ST_OK;
    dec_k      = '0;
    if (req.opcode == OP_INS_FRONT || req.opcode == OP_INS_BACK ||
        req.opcode == OP_INS_POS) begin
      if (req.opcode == OP_INS_POS && pos_w == '0) begin
        dec_status = ST_INVALID;
      end else if (n_w >= CMP_W'(CAPACITY)) begin
        dec_status = ST_FULL;
      end else if (req.opcode != OP_INS_POS || pos_w == CMP_W'(1)) begin
        if (n_w == '0) begin
          dec_kind = K_INS_EMPTY;
        end else begin
          dec_kind = K_INS_END;
          dec_k    = n_w - CMP_W'(1);
        end
      end else if (n_w == '0 || pos_w > n_w) begin
        dec_status = ST_RANGE;
      end else begin
        dec_kind = K_INS_MID;
        dec_k    = pos_w - CMP_W'(2);
      end
    end else if (req.opcode == OP_DEL_FRONT || req.opcode == OP_DEL_BACK ||
                 req.opcode == OP_DEL_POS) begin
      if (n_w == '0) begin
        dec_status = ST_EMPTY;
      end else if (req.opcode == OP_DEL_POS && pos_w == '0) begin
        dec_status = ST_INVALID;
      end else if (req.opcode == OP_DEL_POS && pos_w != CMP_W'(1) && pos_w > n_w) begin
        dec_status = ST_RANGE;
      end else if (n_w == CMP_W'(1)) begin
        dec_kind = K_DEL_ONLY;
      end else if (req.opcode == OP_DEL_FRONT ||
                   (req.opcode == OP_DEL_POS && pos_w == CMP_W'(1))) begin
        dec_kind = K_DEL_HEAD;
        dec_k    = n_w - CMP_W'(1);
      end else begin
        dec_kind = K_DEL_MID;
        dec_k    = (req.opcode == OP_DEL_BACK) ? (n_w - CMP_W'(2)) : (pos_w - CMP_W'(2));
      end
    end
  end

  // Pick the lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  // Current walk position: fresh link data once a step is in flight
  assign eff       = pend ? link_rdata : cur;
  assign walk_done = (rem == '0);
  assign is_del    = (kind == K_DEL_ONLY) || (kind == K_DEL_HEAD) || (kind == K_DEL_MID);

  // Link store read port: walk steps, successor fetch, victim successor
  always_comb begin
    link_re    = 1'b0;
    link_raddr = cur;
    if (cmd.walk && !walk_done) begin
      link_re    = 1'b1;
      link_raddr = eff;
    end else if (cmd.fetch) begin
      link_re    = 1'b1;
      link_raddr = (kind == K_DEL_HEAD || kind == K_DEL_ONLY) ? head : cur;
    end else if (cmd.victim) begin
      link_re    = 1'b1;
      link_raddr = link_rdata;
    end
  end

  // Link store write port: new element, predecessor, bypass on delete
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = head;
    if (cmd.link_new) begin
      link_we    = 1'b1;
      link_waddr = slot;
      if (kind == K_INS_MID) begin
        link_wdata = link_rdata;
      end else if (kind == K_INS_EMPTY) begin
        link_wdata = slot;
      end else begin
        link_wdata = head;
      end
    end else if (cmd.link_prev) begin
      link_we    = 1'b1;
      link_waddr = cur;
      link_wdata = slot;
    end else if (cmd.finish && (kind == K_DEL_HEAD || kind == K_DEL_MID)) begin
      link_we    = 1'b1;
      link_waddr = cur;
      link_wdata = link_rdata;
    end
  end

  // Element store reads the head or the victim
  assign elem_re    = cmd.fetch || cmd.victim;
  assign elem_raddr = cmd.victim ? link_rdata : head;

  clid_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  clid_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (cmd.link_new),
    .waddr (slot),
    .wdata (req_q.value),
    .re    (elem_re),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  // Commit list state at the end of a request
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      free_map <= '1;
    end else if (cmd.finish) begin
      case (kind)
        K_INS_EMPTY, K_INS_END, K_INS_MID: begin
          free_map[slot] <= 1'b0;
          count          <= count + CNT_W'(1);
          if (kind == K_INS_EMPTY ||
              (kind == K_INS_END && req_q.opcode != OP_INS_BACK)) begin
            head <= slot;
          end
        end
        K_DEL_ONLY: begin
          free_map[head] <= 1'b1;
          count          <= count - CNT_W'(1);
        end
        K_DEL_HEAD: begin
          free_map[head] <= 1'b1;
          head           <= link_rdata;
          count          <= count - CNT_W'(1);
        end
        K_DEL_MID: begin
          free_map[vic] <= 1'b1;
          count         <= count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Track whether link read data holds the current walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
    end else if (cmd.walk) begin
      pend <= !walk_done;
    end
  end

  // Latch the request, advance the walk, capture victim and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req;
      kind      <= dec_kind;
      status_q  <= dec_status;
      removed_q <= '0;
      cur       <= head;
      rem       <= dec_k[IDX_W-1:0];
      slot      <= free_slot;
    end
    if (cmd.walk) begin
      cur <= eff;
      if (!walk_done) begin
        rem <= rem - IDX_W'(1);
      end
    end
    if (cmd.victim) begin
      vic <= link_rdata;
    end
    if (cmd.finish && is_del) begin
      removed_q <= elem_rdata;
    end
  end

  assign sts.dec_kind  = dec_kind;
  assign sts.kind      = kind;
  assign sts.walk_done = walk_done;

  assign rsp.status        = status_q;
  assign rsp.removed_value = removed_q;
  assign rsp.count         = CNT_OUT_W'(count);

endmodule

FILE: sv/circular_list_insert_delete_unit.sv
// Top level of the circular list unit: controller plus datapath.
// Depends on clid_pkg, clid_ctrl, clid_dp (and clid_ram below it).
//
// Usage:
//   Request word: opcode, value, position on "request". A word is taken at
//   a rising edge with start high and busy low. busy stays high from the
//   cycle after that edge until the response has been shown.
//   Response word: status, removed_value, count on "response", valid for
//   exactly one cycle while done is high. There is no back-pressure; the
//   receiver must take the word in that cycle.
// Sequence:
//   Rejected requests and unused opcodes answer in the cycle after accept.
//   Insert into an empty list skips the walk (link-new, finish, done), as
//   does delete of the only element (fetch, finish, done). Other requests
//   walk the links from the head one slot per cycle through the link store's
//   read port, following up to count - 1 links before the reads and link
//   updates. A new request is taken in the cycle after done.
// Reset:
//   rst (synchronous) empties the list and frees every slot; no clearing
//   pass is needed and a request can be taken in the first cycle after.
module circular_list_insert_delete_unit #(
  parameter int CAPACITY = clid_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  clid_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output clid_pkg::rsp_t response
);
  import clid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  clid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  clid_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (request),
    .sts (sts),
    .rsp (response)
  );

endmodule

FILE: sv/clid_checker.sv
// Port-level checker for the circular list unit, bound to the top level.
// Depends on clid_pkg.
module clid_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input clid_pkg::rsp_t response
);
  import clid_pkg::*;

  // Response shows only while a request is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("response strobe outside a busy request");

  // One response per request, then back to idle
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("response strobe longer than one cycle");

  // An accepted word starts a request
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start a request");

  // Failed requests remove nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.status != ST_OK) |-> (response.removed_value == '0))
    else $error("failed request reports a removed word");

  // Empty status only on an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && response.status == ST_EMPTY) |-> (response.count == '0))
    else $error("empty status with nonzero count");

endmodule

bind circular_list_insert_delete_unit clid_checker u_clid_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .response (response)
);

FILE: sim/circular_list_insert_delete_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for circular_list_insert_delete_unit: directed and random list requests.
// A mirror of the list predicts every response word. Depends on clid_pkg and the RTL.
module circular_list_insert_delete_unit_tb;
  import clid_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int REQ_W = $bits(req_t);

  // Opcodes the unit ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Mirror of the list contents, in list order from the head, and the owed responses
  class list_mirror;
    logic signed [VAL_W-1:0] words[$];
    rsp_t owed_rsp[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its response
    function void note_request(req_t r);
      rsp_t e;
      int n;
      int p;
      int idx;
      n = words.size();
      p = r.position;
      e.status = ST_OK;
      e.removed_value = '0;
      case (r.opcode)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
          if (r.opcode == OP_INS_POS && p == 0) begin
            e.status = ST_INVALID;
          end else if (n >= CAPACITY) begin
            e.status = ST_FULL;
          end else if (r.opcode == OP_INS_FRONT || (r.opcode == OP_INS_POS && p == 1)) begin
            words.push_front(r.value);
          end else if (r.opcode == OP_INS_BACK) begin
            words.push_back(r.value);
          end else if (p > n) begin
            e.status = ST_RANGE;
          end else begin
            words.insert(p - 1, r.value);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
          if (n == 0) begin
            e.status = ST_EMPTY;
          end else if (r.opcode == OP_DEL_POS && p == 0) begin
            e.status = ST_INVALID;
          end else if (r.opcode == OP_DEL_POS && p > n) begin
            e.status = ST_RANGE;
          end else begin
            if (r.opcode == OP_DEL_FRONT) idx = 0;
            else if (r.opcode == OP_DEL_BACK) idx = n - 1;
            else idx = p - 1;
            e.removed_value = words[idx];
            words.delete(idx);
          end
        end
        default: ;
      endcase
      e.count = CNT_OUT_W'(words.size());
      owed_rsp.push_back(e);
    endfunction

    // Compare one response word with the oldest owed one
    function void check_response(rsp_t a);
      rsp_t e;
      if (owed_rsp.size() == 0) begin
        $error("response with none owed: status %0d removed_value %0d count %0d",
               a.status, a.removed_value, a.count);
        failures++;
        return;
      end
      e = owed_rsp.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        failures++;
      end
      if (a.removed_value !== e.removed_value) begin
        $error("removed_value: expected %0d, actual %0d", e.removed_value, a.removed_value);
        failures++;
      end
      if (a.count !== e.count) begin
        $error("count: expected %0d, actual %0d", e.count, a.count);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  rsp_t response;

  list_mirror mirror;
  int burst_left;
  int cycle_count;

  circular_list_insert_delete_unit #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .response(response)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check each response word in its one valid cycle
  always @(posedge clk) begin
    if (!rst && done) mirror.check_response(response);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                    logic [POS_W-1:0] pos);
    req_t r;
    r.opcode = op;
    r.value = v;
    r.position = pos;
    return r;
  endfunction

  // Random request, leaning toward inserts while filling and deletes while draining
  function automatic req_t random_req(bit filling);
    req_t r;
    int n;
    int k;
    n = mirror.words.size();
    k = $urandom_range(0, 99);
    if (k < 3) begin
      r.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else if ((k < 72) == filling) begin
      case ($urandom_range(0, 2))
        0: r.opcode = OP_INS_FRONT;
        1: r.opcode = OP_INS_BACK;
        default: r.opcode = OP_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: r.opcode = OP_DEL_FRONT;
        1: r.opcode = OP_DEL_BACK;
        default: r.opcode = OP_DEL_POS;
      endcase
    end
    case ($urandom_range(0, 9))
      0: r.position = '0;
      1: r.position = POS_W'($urandom_range(0, 255));
      2: r.position = POS_W'(n + 1);
      default: r.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
    endcase
    case ($urandom_range(0, 9))
      0: r.value = VAL_MIN;
      1: r.value = VAL_MAX;
      2: r.value = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  // Present one request word and hold it until the unit takes it
  task automatic issue(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      start <= 1'b0;
      request <= REQ_W'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_request(r);
    burst_left--;
  endtask

  initial begin
    req_t directed[$];
    bit filling;
    int phase_left;
    mirror = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    burst_left = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty list, bad positions, ignored opcodes, extremes, sole and later deletes
    directed.push_back(make_req(OP_DEL_FRONT, 32'sd7, 8'd0));
    directed.push_back(make_req(OP_DEL_BACK, 32'sd7, 8'd0));
    directed.push_back(make_req(OP_DEL_POS, 32'sd7, 8'd0));
    directed.push_back(make_req(OP_DEL_POS, 32'sd7, 8'd255));
    directed.push_back(make_req(OP_INS_POS, 32'sd9, 8'd0));
    directed.push_back(make_req(OP_INS_POS, 32'sd9, 8'd2));
    directed.push_back(make_req(OP_SPARE_A, 32'sd1, 8'd1));
    directed.push_back(make_req(OP_INS_POS, VAL_MIN, 8'd1));
    directed.push_back(make_req(OP_DEL_BACK, 32'sd0, 8'd0));
    directed.push_back(make_req(OP_INS_FRONT, VAL_MAX, 8'd0));
    directed.push_back(make_req(OP_INS_BACK, -32'sd1, 8'd255));
    directed.push_back(make_req(OP_INS_BACK, 32'sd0, 8'd0));
    directed.push_back(make_req(OP_INS_POS, 32'sd5, 8'd3));
    directed.push_back(make_req(OP_INS_POS, 32'sd6, 8'd5));
    directed.push_back(make_req(OP_INS_POS, 32'sd6, 8'd255));
    directed.push_back(make_req(OP_SPARE_B, VAL_MIN, 8'd255));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd0));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd5));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd255));
    directed.push_back(make_req(OP_DEL_BACK, 32'sd0, 8'd0));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd3));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd2));
    directed.push_back(make_req(OP_DEL_POS, 32'sd0, 8'd1));
    directed.push_back(make_req(OP_INS_BACK, 32'sh5555_5555, 8'd0));
    directed.push_back(make_req(OP_DEL_FRONT, 32'sd0, 8'd0));
    foreach (directed[i]) issue(directed[i]);

    // Random phases that swing the list between empty and full
    filling = 1'b1;
    phase_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(10, 60);
      end
      issue(random_req(filling));
      phase_left--;
    end
    start <= 1'b0;

    // Drain, then watch for stray words
    while (mirror.owed_rsp.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.failures == 0 && mirror.owed_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
